>>> sv/occlusion_edge_valid_mask_core_defines.svh
// Assertion macros shared by the occlusion mask RTL.
// Both sample on the rising edge of clk.
`ifndef OCCLUSION_EDGE_VALID_MASK_CORE_DEFINES_SVH
`define OCCLUSION_EDGE_VALID_MASK_CORE_DEFINES_SVH

// Check that is switched off while rst is high.
`define OEVM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check that also holds across reset.
`define OEVM_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

>>> sv/oevm_pkg.sv
`timescale 1ns / 1ps
package oevm_pkg;

  // Widths fixed by the item and register formats
  localparam int LABEL_W = 16;
  localparam int DEPTH_IN_W = 16;
  localparam int IMG_W_W = 11;
  localparam int IMG_H_W = 13;
  localparam int ROW_W = 12;
  localparam int MAX_HEIGHT = 4096;

  // Register reset values
  localparam logic [IMG_W_W-1:0] WIDTH_RESET = 11'd640;
  localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 13'd480;

  // Register indexes (paddr bit 2)
  localparam logic REG_WIDTH = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // Default sizes
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_DEPTH_BITS = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  // Control word carried from the front end to the back end
  typedef struct packed {
    logic pixel;      // item writes the line store and shifts the window
    logic emit;       // item produces a result beat
    logic check;      // result comes from the window test
    logic frame_end;  // last result of the frame
  } ctl_t;

  // Result beat
  typedef struct packed {
    logic pixel_valid;
    logic frame_end;
  } res_t;

endpackage

>>> sv/oevm_fifo.sv
`timescale 1ns / 1ps
module oevm_fifo import oevm_pkg::*; #(
  parameter int WIDTH = 2,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNTW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNTW'(1);
      end
    end
  end

endmodule

>>> sv/oevm_front.sv
`timescale 1ns / 1ps
module oevm_front import oevm_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int DW = DEF_DEPTH_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic                           kind,
  input  logic [LABEL_W-1:0]             instance_label,
  input  logic [DEPTH_IN_W-1:0]          pixel_depth,
  input  logic [$clog2(MAX_WIDTH+1)-1:0] w_eff,
  input  logic [IMG_H_W-1:0]             h_eff,
  input  logic                           q_full,
  output logic                           q_push,
  output ctl_t                           q_ctl,
  output logic [LABEL_W-1:0]             q_label,
  output logic [DW-1:0]                  q_depth,
  output logic [$clog2(MAX_WIDTH)-1:0]   q_col
);

  localparam int EW = $clog2(MAX_WIDTH + 1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int DLW = $clog2(MAX_WIDTH + 2);

  logic [CW-1:0]    column_count;
  logic [CW-1:0]    column_count_next;
  logic [ROW_W-1:0] row_count;
  logic [ROW_W-1:0] row_count_next;
  logic [DLW-1:0]   drain_left;
  logic [DLW-1:0]   drain_left_next;
  logic             drain_due;
  logic             row_end;
  logic             frame_last;
  logic [EW-1:0]    col_ext;
  logic [IMG_H_W-1:0] row_ext;

  assign full    = q_full;
  assign q_push  = push && !q_full;
  assign q_label = instance_label;
  assign q_depth = pixel_depth[DW-1:0];
  assign q_col   = column_count;

  assign col_ext    = EW'(column_count);
  assign row_ext    = IMG_H_W'(row_count);
  assign drain_due  = (drain_left != '0);
  assign row_end    = (col_ext >= w_eff - EW'(1));
  assign frame_last = (row_ext >= h_eff - IMG_H_W'(1));

  // Classify the item: pending drain result first, then the window result
  always_comb begin
    q_ctl.pixel     = (kind == KIND_PIXEL);
    q_ctl.frame_end = drain_due && (drain_left == DLW'(1));
    q_ctl.emit      = drain_due;
    q_ctl.check     = 1'b0;
    if (!drain_due && kind == KIND_PIXEL &&
        (row_count >= ROW_W'(2) || (row_count == ROW_W'(1) && column_count != '0))) begin
      q_ctl.emit  = 1'b1;
      q_ctl.check = (row_count >= ROW_W'(2)) && (row_ext <= h_eff - IMG_H_W'(1)) &&
                    (column_count >= CW'(2)) && (col_ext <= w_eff - EW'(1));
    end
  end

  // Raster position and drain count
  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    drain_left_next   = drain_due ? drain_left - DLW'(1) : drain_left;
    if (kind == KIND_PIXEL) begin
      if (row_end) begin
        column_count_next = '0;
        if (frame_last) begin
          row_count_next  = '0;
          drain_left_next = DLW'(w_eff) + DLW'(1);
        end else begin
          row_count_next = row_count + ROW_W'(1);
        end
      end else begin
        column_count_next = column_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      drain_left   <= '0;
    end else if (q_push) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      drain_left   <= drain_left_next;
    end
  end

endmodule

>>> sv/oevm_back.sv
`timescale 1ns / 1ps
module oevm_back import oevm_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int DW = DEF_DEPTH_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  input  ctl_t                         q_ctl,
  input  logic [LABEL_W-1:0]           q_label,
  input  logic [DW-1:0]                q_depth,
  input  logic [$clog2(MAX_WIDTH)-1:0] q_col,
  output logic                         q_pop,
  input  logic                         out_full,
  output logic                         out_push,
  output res_t                         out_res
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EntW = 2 * (LABEL_W + DW);

  // Line store entry: two rows of one column, older row in the upper half
  logic [EntW-1:0]    line_mem [MAX_WIDTH];
  logic [EntW-1:0]    rd_q;
  logic [LABEL_W-1:0] rd_top_lab;
  logic [DW-1:0]      rd_top_dep;
  logic [LABEL_W-1:0] rd_mid_lab;
  logic [DW-1:0]      rd_mid_dep;

  logic               s1_valid;
  ctl_t               s1_ctl;
  logic [LABEL_W-1:0] s1_label;
  logic [DW-1:0]      s1_depth;
  logic [CW-1:0]      s1_col;
  logic               s1_fire;
  logic               load;

  logic [LABEL_W-1:0] win_lab [3][3];
  logic [DW-1:0]      win_dep [3][3];
  logic [LABEL_W-1:0] nxt_lab [3][3];
  logic [DW-1:0]      nxt_dep [3][3];
  logic               centre_ok;

  assign {rd_top_lab, rd_top_dep, rd_mid_lab, rd_mid_dep} = rd_q;

  assign s1_fire = s1_valid && (!s1_ctl.emit || !out_full);
  assign load    = !q_empty && (!s1_valid || s1_fire);
  assign q_pop   = load;

  // Stage 1 register, loaded together with the line store read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_ctl   <= q_ctl;
      s1_label <= q_label;
      s1_depth <= q_depth;
      s1_col   <= q_col;
    end
  end

  // Line store: read at load, column rotate-and-write when the pixel retires
  always_ff @(posedge clk) begin
    if (load) begin
      rd_q <= line_mem[q_col];
    end
    if (s1_fire && s1_ctl.pixel) begin
      line_mem[s1_col] <= {rd_mid_lab, rd_mid_dep, s1_label, s1_depth};
    end
  end

  // Window after the shift: new column enters on the right
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      nxt_lab[r][0] = win_lab[r][1];
      nxt_dep[r][0] = win_dep[r][1];
      nxt_lab[r][1] = win_lab[r][2];
      nxt_dep[r][1] = win_dep[r][2];
    end
    nxt_lab[0][2] = rd_top_lab;
    nxt_dep[0][2] = rd_top_dep;
    nxt_lab[1][2] = rd_mid_lab;
    nxt_dep[1][2] = rd_mid_dep;
    nxt_lab[2][2] = s1_label;
    nxt_dep[2][2] = s1_depth;
  end

  // Occlusion test: a closer neighbor of another object clears the flag
  always_comb begin
    centre_ok = 1'b1;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (nxt_lab[r][c] != nxt_lab[1][1] && nxt_lab[r][c] != '0 &&
            nxt_dep[r][c] < nxt_dep[1][1]) begin
          centre_ok = 1'b0;
        end
      end
    end
    if (nxt_lab[1][1] == '0) begin
      centre_ok = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_ctl.pixel) begin
      win_lab <= nxt_lab;
      win_dep <= nxt_dep;
    end
  end

  // Result beat
  assign out_push            = s1_fire && s1_ctl.emit;
  assign out_res.pixel_valid = s1_ctl.check ? centre_ok : 1'b1;
  assign out_res.frame_end   = s1_ctl.frame_end;

endmodule

>>> sv/occlusion_edge_valid_mask_core.sv
`timescale 1ns / 1ps
// A result beat passes the command queue, then the line store read and window test in
// stage 1, then the result queue; results trail pixels by width+1 items. Throughput:
// one item per cycle while the result queue has room, set by the line store doing one
// read and one write per cycle. Reset (rst, synchronous) clears position counters,
// queues and sizes (640 x 480); the line store is not cleared.
`include "occlusion_edge_valid_mask_core_defines.svh"
module occlusion_edge_valid_mask_core import oevm_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int DEPTH_BITS = DEF_DEPTH_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic                  kind,
  input  logic [LABEL_W-1:0]    instance_label,
  input  logic [DEPTH_IN_W-1:0] pixel_depth,
  input  logic                  pop,
  output logic                  empty,
  output logic                  pixel_valid,
  output logic                  frame_end,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int DW = (DEPTH_BITS < DEPTH_IN_W) ? DEPTH_BITS : DEPTH_IN_W;
  localparam int EW = $clog2(MAX_WIDTH + 1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int QW = $bits(ctl_t) + LABEL_W + DW + CW;

  logic [IMG_W_W-1:0] image_width;
  logic [IMG_H_W-1:0] image_height;
  logic [EW-1:0]      w_eff;
  logic [IMG_H_W-1:0] h_eff;
  logic               cfg_wr;

  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  ctl_t               f_ctl;
  logic [LABEL_W-1:0] f_label;
  logic [DW-1:0]      f_depth;
  logic [CW-1:0]      f_col;
  ctl_t               b_ctl;
  logic [LABEL_W-1:0] b_label;
  logic [DW-1:0]      b_depth;
  logic [CW-1:0]      b_col;

  logic               out_push;
  logic               out_full;
  res_t               out_res;
  res_t               head_res;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_WIDTH:  image_width  <= pwdata[IMG_W_W-1:0];
        REG_HEIGHT: image_height <= pwdata[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = 32'(image_width);
      REG_HEIGHT: prdata = 32'(image_height);
      default:    prdata = '0;
    endcase
  end

  // Sizes in use, clamped into range
  always_comb begin
    if (image_width < IMG_W_W'(3)) begin
      w_eff = EW'(3);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(image_width);
    end
    if (image_height < IMG_H_W'(3)) begin
      h_eff = IMG_H_W'(3);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      h_eff = IMG_H_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
  end

  oevm_front #(.MAX_WIDTH(MAX_WIDTH), .DW(DW)) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .kind           (kind),
    .instance_label (instance_label),
    .pixel_depth    (pixel_depth),
    .w_eff          (w_eff),
    .h_eff          (h_eff),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_ctl          (f_ctl),
    .q_label        (f_label),
    .q_depth        (f_depth),
    .q_col          (f_col)
  );

  // Queue between classifier and window engine
  oevm_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata ({f_ctl, f_label, f_depth, f_col}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata ({b_ctl, b_label, b_depth, b_col}),
    .empty (q_empty)
  );

  oevm_back #(.MAX_WIDTH(MAX_WIDTH), .DW(DW)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_ctl    (b_ctl),
    .q_label  (b_label),
    .q_depth  (b_depth),
    .q_col    (b_col),
    .q_pop    (q_pop),
    .out_full (out_full),
    .out_push (out_push),
    .out_res  (out_res)
  );

  // Result queue toward the consumer
  oevm_fifo #(.WIDTH($bits(res_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_res),
    .full  (out_full),
    .pop   (pop),
    .rdata (head_res),
    .empty (empty)
  );

  assign pixel_valid = head_res.pixel_valid;
  assign frame_end   = head_res.frame_end;

  `OEVM_ASSERT(a_out_no_overflow, out_push |-> !out_full, "result pushed into full queue")
  `OEVM_ASSERT(a_frame_end_valid, (!empty && frame_end) |-> pixel_valid, "frame end not valid")
  `OEVM_ASSERT_ALWAYS(a_reset_empty, rst |=> (empty && q_empty), "queues not empty after reset")

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
module tb;
  import oevm_pkg::*;

  localparam int LINE_W = DEF_MAX_WIDTH;
  localparam int LIMIT = 200000;
  localparam int HOLD_AFTER = 60;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_FROM = 1500;
  localparam int QUIET_TO = 3500;
  localparam int SETTLE_CYCLES = 10;

  typedef struct packed {
    logic                  kind;
    logic [LABEL_W-1:0]    label;
    logic [DEPTH_IN_W-1:0] depth;
  } pixel_item_t;

  // DUT inputs, all known from time zero
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  kind = KIND_PIXEL;
  logic [LABEL_W-1:0]    instance_label = '0;
  logic [DEPTH_IN_W-1:0] pixel_depth = '0;
  logic                  pop = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [2:0]            paddr = '0;
  logic [31:0]           pwdata = '0;

  logic        full, empty, pixel_valid, frame_end, pready;
  logic [31:0] prdata;

  occlusion_edge_valid_mask_core u_top (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .kind(kind), .instance_label(instance_label), .pixel_depth(pixel_depth),
    .pop(pop), .empty(empty),
    .pixel_valid(pixel_valid), .frame_end(frame_end),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Low phase first, so there is no edge at time zero
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Mask predictor state
  logic [IMG_W_W-1:0]    cfg_width = WIDTH_RESET;
  logic [IMG_H_W-1:0]    cfg_height = HEIGHT_RESET;
  logic [LABEL_W-1:0]    lab_line [2*LINE_W] = '{default: '0};
  logic [DEPTH_IN_W-1:0] dep_line [2*LINE_W] = '{default: '0};
  logic [LABEL_W-1:0]    win_lab [3][3] = '{default: '0};
  logic [DEPTH_IN_W-1:0] win_dep [3][3] = '{default: '0};
  int unsigned           col_cnt = 0;
  int unsigned           row_cnt = 0;
  int unsigned           drain_cnt = 0;

  pixel_item_t pending_pixels[$];
  res_t        expected_mask[$];
  pixel_item_t taken;
  res_t        want;
  int unsigned cyc = 0;
  int unsigned errors = 0;
  int unsigned beats_seen = 0;
  int unsigned hold_left = 0;

  function automatic int unsigned clamp3(int unsigned v, int unsigned hi);
    return (v < 3) ? 3 : (v > hi) ? hi : v;
  endfunction

  function automatic bit idle_roll();
    if (cyc >= QUIET_FROM && cyc < QUIET_TO) return 1'b0;
    return $urandom_range(0, 99) < 16;
  endfunction

  // Advance the mask predictor by one accepted item
  task automatic mask_step(input pixel_item_t it);
    int unsigned w, h, r, c, col, ln;
    bit produced, ok;
    res_t beat;
    w = clamp3(cfg_width, LINE_W);
    h = clamp3(cfg_height, MAX_HEIGHT);
    produced = 1'b0;
    // leftover border results of the previous frame go first
    if (drain_cnt > 0) begin
      beat.pixel_valid = 1'b1;
      beat.frame_end = (drain_cnt == 1);
      expected_mask.push_back(beat);
      drain_cnt--;
      produced = 1'b1;
    end
    if (it.kind == KIND_DRAIN) return;
    r = row_cnt;
    c = col_cnt;
    col = c % LINE_W;
    ln = LINE_W + col;
    // shift window, new column from the two lines and the new pixel
    for (int i = 0; i < 3; i++) begin
      win_lab[i][0] = win_lab[i][1];
      win_lab[i][1] = win_lab[i][2];
      win_dep[i][0] = win_dep[i][1];
      win_dep[i][1] = win_dep[i][2];
    end
    win_lab[0][2] = lab_line[col];
    win_dep[0][2] = dep_line[col];
    win_lab[1][2] = lab_line[ln];
    win_dep[1][2] = dep_line[ln];
    win_lab[2][2] = it.label;
    win_dep[2][2] = it.depth;
    lab_line[col] = lab_line[ln];
    dep_line[col] = dep_line[ln];
    lab_line[ln] = it.label;
    dep_line[ln] = it.depth;
    // in-frame result for the pixel width+1 back
    if (!produced && (r >= 2 || (r == 1 && c >= 1))) begin
      ok = 1'b1;
      if (r >= 2 && r <= h - 1 && c >= 2 && c <= w - 1 && win_lab[1][1] != 0) begin
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++)
            if (win_lab[i][j] != win_lab[1][1] && win_lab[i][j] != 0 &&
                win_dep[i][j] < win_dep[1][1])
              ok = 1'b0;
      end
      beat.pixel_valid = ok;
      beat.frame_end = 1'b0;
      expected_mask.push_back(beat);
    end
    // row and frame position
    if (c >= w - 1) begin
      col_cnt = 0;
      if (r >= h - 1) begin
        row_cnt = 0;
        drain_cnt = w + 1;
      end else begin
        row_cnt = r + 1;
      end
    end else begin
      col_cnt = c + 1;
    end
  endtask

  // Pixel driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        taken = pending_pixels.pop_front();
        mask_step(taken);
      end
      if (!(push && full)) begin
        if (pending_pixels.size() != 0 && !idle_roll()) begin
          push <= 1'b1;
          kind <= pending_pixels[0].kind;
          instance_label <= pending_pixels[0].label;
          pixel_depth <= pending_pixels[0].depth;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result monitor, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_mask.size() == 0) begin
          $error("unexpected beat: pixel_valid %0b frame_end %0b", pixel_valid, frame_end);
          errors++;
        end else begin
          want = expected_mask.pop_front();
          if (pixel_valid !== want.pixel_valid) begin
            $error("pixel_valid: expected %0b, got %0b", want.pixel_valid, pixel_valid);
            errors++;
          end
          if (frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, frame_end);
            errors++;
          end
        end
        beats_seen++;
        if (beats_seen == HOLD_AFTER) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= !idle_roll();
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // APB write; the block is idle, so the predictor takes the value at once
  task automatic reg_write(input logic idx, input int unsigned value);
    logic [31:0] data;
    data = $urandom_range(0, 1) ? $urandom : 32'd0;
    if (idx == REG_WIDTH) begin
      data[IMG_W_W-1:0] = IMG_W_W'(value);
      cfg_width = IMG_W_W'(value);
    end else begin
      data[IMG_H_W-1:0] = IMG_H_W'(value);
      cfg_height = IMG_H_W'(value);
    end
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_size(input int unsigned w, input int unsigned h);
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
  endtask

  // Wait until every item is taken and every beat is back, then let the pipe drain
  task automatic settle();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || push || expected_mask.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic pixel_item_t px(input logic [15:0] lab, input logic [15:0] dep);
    return '{kind: KIND_PIXEL, label: lab, depth: dep};
  endfunction

  function automatic pixel_item_t drain_item();
    return '{kind: KIND_DRAIN, label: LABEL_W'($urandom), depth: DEPTH_IN_W'($urandom)};
  endfunction

  // Labels cluster on a few values so that edges between objects are common
  function automatic pixel_item_t rand_pixel();
    int unsigned roll;
    logic [LABEL_W-1:0] lab;
    logic [DEPTH_IN_W-1:0] dep;
    roll = $urandom_range(0, 9);
    if (roll <= 2) lab = '0;
    else if (roll <= 7) lab = LABEL_W'($urandom_range(1, 3));
    else if (roll == 8) lab = '1;
    else lab = LABEL_W'($urandom);
    dep = $urandom_range(0, 1) ? DEPTH_IN_W'($urandom_range(0, 7)) : DEPTH_IN_W'($urandom);
    return px(lab, dep);
  endfunction

  // Mostly whole frames with their drain beats; some broken ones and stray drains
  task automatic fill_random(input int unsigned w, input int unsigned h,
                             input int unsigned budget, input bit tail_frame);
    int unsigned n, roll, k;
    n = 0;
    while (n < budget) begin
      roll = $urandom_range(0, 9);
      if (roll == 9) begin
        k = $urandom_range(1, 3);
        for (int i = 0; i < k && n < budget; i++) begin
          pending_pixels.push_back(drain_item());
          n++;
        end
        k = $urandom_range(1, 2 * w);
        for (int i = 0; i < k && n < budget; i++) begin
          pending_pixels.push_back(rand_pixel());
          n++;
        end
      end else begin
        for (int p = 0; p < w * h && n < budget; p++) begin
          pending_pixels.push_back(rand_pixel());
          n++;
        end
        k = w + 1;
        if (roll == 7) k = $urandom_range(0, w);
        if (roll == 8) k = w + 1 + $urandom_range(1, 3);
        for (int i = 0; i < k && n < budget; i++) begin
          pending_pixels.push_back(drain_item());
          n++;
        end
      end
    end
    // whole frame with no drains: the next phase starts with results pending
    if (tail_frame) begin
      repeat (w * h) pending_pixels.push_back(rand_pixel());
    end
  endtask

  task automatic run_phase(input int unsigned w, input int unsigned h,
                           input int unsigned budget, input bit tail_frame);
    set_size(w, h);
    @(negedge clk);
    fill_random(clamp3(w, LINE_W), clamp3(h, MAX_HEIGHT), budget, tail_frame);
    settle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: smallest frame, extreme labels and depths
    set_size(3, 3);
    @(negedge clk);
    // frame with an occluded centre
    pending_pixels.push_back(px(16'd1, 16'hFFFF));
    pending_pixels.push_back(px(16'hFFFF, 16'h0000));
    pending_pixels.push_back(px(16'd0, 16'h1234));
    pending_pixels.push_back(px(16'd2, 16'h0000));
    pending_pixels.push_back(px(16'd1, 16'hFFFF));
    pending_pixels.push_back(px(16'hFFFF, 16'h0000));
    pending_pixels.push_back(px(16'd0, 16'h0000));
    pending_pixels.push_back(px(16'd1, 16'h0000));
    pending_pixels.push_back(px(16'd2, 16'h0008));
    // only part of the drain, so the next frame flushes the rest
    repeat (2) pending_pixels.push_back(drain_item());
    // frame whose centre ties on depth with other labels: stays valid
    pending_pixels.push_back(px(16'd5, 16'h0000));
    pending_pixels.push_back(px(16'd5, 16'hFFFF));
    pending_pixels.push_back(px(16'd0, 16'h0000));
    pending_pixels.push_back(px(16'd3, 16'h0064));
    pending_pixels.push_back(px(16'd5, 16'h0000));
    pending_pixels.push_back(px(16'd3, 16'h0000));
    pending_pixels.push_back(px(16'd0, 16'hFFFF));
    pending_pixels.push_back(px(16'd5, 16'h0001));
    pending_pixels.push_back(px(16'd3, 16'h0000));
    // full drain, then one drain with nothing left
    repeat (5) pending_pixels.push_back(drain_item());
    settle();

    // Random phases; out-of-range sizes saturate, some phases end mid-frame
    run_phase(3, 3, 80, 1'b0);
    run_phase(7, 3, 80, 1'b1);
    run_phase(0, 0, 60, 1'b0);
    run_phase(2, 1, 50, 1'b0);
    run_phase(4, 5, 80, 1'b0);
    run_phase(16, 4, 100, 1'b1);
    run_phase(5, 8191, 50, 1'b0);
    run_phase(33, 6, 120, 1'b0);
    run_phase(2047, 4, 1100, 1'b0);
    run_phase(9, 2, 50, 1'b0);
    run_phase(12, 7, 80, 1'b0);

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
